/* src/krt_pkg.sv */
`default_nettype none

package krt_pkg;

    // table size default
    localparam int MAX_ENTRIES_DEF = 10;

    // text and record widths
    localparam int KEY_BYTES  = 29;
    localparam int KIND_BYTES = 19;
    localparam int KEY_W      = 8 * KEY_BYTES;
    localparam int KIND_W     = 8 * KIND_BYTES;
    localparam int AMOUNT_W   = 32;
    localparam int FILL_W     = 7;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // one stored record, text packed with byte i at bits 8i+7:8i
    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
    } record_t;

    localparam int REC_W = $bits(record_t);

    // controller to datapath commands
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic                wsel_rd;
        logic                cap_in;
        logic                cap_rd;
        logic                load_out;
        logic                zero_out;
        logic                last;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic match;
        logic out_free;
    } dp_stat_t;

    // clear every byte after the first nul of a name
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] t);
        logic             ended;
        logic [KEY_W-1:0] r;
        ended = 1'b0;
        r     = t;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (ended)
                r[8*i +: 8] = 8'h00;
            else if (t[8*i +: 8] == 8'h00)
                ended = 1'b1;
        end
        return r;
    endfunction

    // clear every byte after the first nul of a type
    function automatic logic [KIND_W-1:0] trim_kind(input logic [KIND_W-1:0] t);
        logic              ended;
        logic [KIND_W-1:0] r;
        ended = 1'b0;
        r     = t;
        for (int i = 0; i < KIND_BYTES; i++)
        begin
            if (ended)
                r[8*i +: 8] = 8'h00;
            else if (t[8*i +: 8] == 8'h00)
                ended = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/krt_cmd_if.sv */
`default_nettype none

interface krt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] key_chunk_0;
    logic [63:0] key_chunk_1;
    logic [63:0] key_chunk_2;
    logic [39:0] key_chunk_3;
    logic [63:0] kind_chunk_0;
    logic [63:0] kind_chunk_1;
    logic [23:0] kind_chunk_2;
    logic signed [31:0] amount_in;

    modport source (
        output valid, opcode, key_chunk_0, key_chunk_1, key_chunk_2, key_chunk_3,
               kind_chunk_0, kind_chunk_1, kind_chunk_2, amount_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, key_chunk_0, key_chunk_1, key_chunk_2, key_chunk_3,
               kind_chunk_0, kind_chunk_1, kind_chunk_2, amount_in,
        output ready
    );
endinterface

`default_nettype wire

/* src/krt_res_if.sv */
`default_nettype none

interface krt_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] found_key_0;
    logic [63:0] found_key_1;
    logic [63:0] found_key_2;
    logic [39:0] found_key_3;
    logic [63:0] found_kind_0;
    logic [63:0] found_kind_1;
    logic [23:0] found_kind_2;
    logic signed [31:0] amount_out;
    logic [6:0]  fill_count;
    logic        last_of_run;

    modport source (
        output valid, status, found_key_0, found_key_1, found_key_2, found_key_3,
               found_kind_0, found_kind_1, found_kind_2, amount_out, fill_count,
               last_of_run,
        input  ready
    );

    modport sink (
        input  valid, status, found_key_0, found_key_1, found_key_2, found_key_3,
               found_kind_0, found_kind_1, found_kind_2, amount_out, fill_count,
               last_of_run,
        output ready
    );
endinterface

`default_nettype wire

/* src/krt_ram.sv */
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
    end

    // registered read port, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/krt_dpath.sv */
`default_nettype none

module krt_dpath #(
    parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire krt_pkg::dp_cmd_t     cmd,
    input  wire logic [IDX_W-1:0]     rd_addr,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire logic [CNT_W-1:0]     count,
    output krt_pkg::dp_stat_t         stat,
    // incoming item payload
    input  wire logic [63:0]          key_chunk_0,
    input  wire logic [63:0]          key_chunk_1,
    input  wire logic [63:0]          key_chunk_2,
    input  wire logic [39:0]          key_chunk_3,
    input  wire logic [63:0]          kind_chunk_0,
    input  wire logic [63:0]          kind_chunk_1,
    input  wire logic [23:0]          kind_chunk_2,
    input  wire logic signed [31:0]   amount_in,
    // result channel
    input  wire logic                 res_ready,
    output logic                      res_valid,
    output logic [1:0]                status,
    output logic [63:0]               found_key_0,
    output logic [63:0]               found_key_1,
    output logic [63:0]               found_key_2,
    output logic [39:0]               found_key_3,
    output logic [63:0]               found_kind_0,
    output logic [63:0]               found_kind_1,
    output logic [23:0]               found_kind_2,
    output logic signed [31:0]        amount_out,
    output logic [6:0]                fill_count,
    output logic                      last_of_run
);
    import krt_pkg::*;

    record_t             rec_reg, rec_next;
    record_t             in_rec;
    record_t             rd_rec;
    logic [REC_W-1:0]    rd_data;
    logic [REC_W-1:0]    wr_data;
    record_t             out_reg, out_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [FILL_W-1:0]   out_fill_reg, out_fill_next;
    logic                out_last_reg, out_last_next;
    logic                out_valid_reg, out_valid_next;

    // record storage
    krt_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rec = record_t'(rd_data);

    // incoming record with text trimmed after the first nul
    always_comb
    begin
        in_rec.key    = trim_key({key_chunk_3, key_chunk_2, key_chunk_1, key_chunk_0});
        in_rec.kind   = trim_kind({kind_chunk_2, kind_chunk_1, kind_chunk_0});
        in_rec.amount = amount_in;
    end

    // write source: new record on insert, last record on remove
    assign wr_data = cmd.wsel_rd ? rd_data : REC_W'(rec_reg);

    // working record
    always_comb
    begin
        rec_next = rec_reg;
        if (cmd.cap_in)
            rec_next = in_rec;
        else if (cmd.cap_rd)
            rec_next = rd_rec;
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    // status back to controller
    assign stat.match    = (rd_rec.key == rec_reg.key);
    assign stat.out_free = !out_valid_reg || res_ready;

    // output register
    always_comb
    begin
        out_next        = out_reg;
        out_status_next = out_status_reg;
        out_fill_next   = out_fill_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        if (cmd.load_out)
        begin
            out_next        = cmd.zero_out ? '0 : rec_reg;
            out_status_next = cmd.status;
            out_fill_next   = FILL_W'(count);
            out_last_next   = cmd.last;
            out_valid_next  = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg        <= out_next;
        out_status_reg <= out_status_next;
        out_fill_reg   <= out_fill_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // result fields
    assign res_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found_key_0  = out_reg.key[63:0];
    assign found_key_1  = out_reg.key[127:64];
    assign found_key_2  = out_reg.key[191:128];
    assign found_key_3  = out_reg.key[231:192];
    assign found_kind_0 = out_reg.kind[63:0];
    assign found_kind_1 = out_reg.kind[127:64];
    assign found_kind_2 = out_reg.kind[151:128];
    assign amount_out   = out_reg.amount;
    assign fill_count   = out_fill_reg;
    assign last_of_run  = out_last_reg;

endmodule

`default_nettype wire

/* src/krt_ctrl.sv */
`default_nettype none

module krt_ctrl #(
    parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic [1:0]           opcode,
    output logic                      in_ready,
    input  wire krt_pkg::dp_stat_t    stat,
    output krt_pkg::dp_cmd_t          cmd,
    output logic [IDX_W-1:0]          rd_addr,
    output logic [IDX_W-1:0]          wr_addr,
    output logic [CNT_W-1:0]          count
);
    import krt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_RM_RD = 3'd4;
    localparam logic [2:0] S_RM_WR = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                zero_reg, zero_next;
    logic                last_reg, last_next;
    logic                at_last;
    logic [CNT_W-1:0]    last_slot;

    // current entry is the last one held
    assign at_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign last_slot = count_reg - CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        op_next     = op_reg;
        status_next = status_reg;
        zero_next   = zero_reg;
        last_next   = last_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        cmd.zero_out = zero_reg;
        cmd.last    = last_reg;
        rd_addr     = idx_reg;
        wr_addr     = idx_reg;
        in_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.cap_in = 1'b1;
                    op_next    = opcode;
                    idx_next   = '0;
                    last_next  = 1'b1;
                    zero_next  = 1'b0;
                    status_next = ST_OK;
                    if (opcode == OP_INSERT)
                    begin
                        if (count_reg >= CNT_W'(MAX_ENTRIES))
                        begin
                            status_next = ST_FULL;
                            zero_next   = 1'b1;
                            state_next  = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_INS;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                        zero_next   = 1'b1;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            // append at the fill position
            S_INS:
            begin
                cmd.wr_en  = 1'b1;
                wr_addr    = count_reg[IDX_W-1:0];
                count_next = count_reg + CNT_W'(1);
                state_next = S_EMIT;
            end

            S_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CMP;
            end

            // read data is valid here
            S_CMP:
            begin
                if (op_reg == OP_LIST)
                begin
                    cmd.cap_rd = 1'b1;
                    last_next  = at_last;
                    state_next = S_EMIT;
                end
                else if (stat.match)
                begin
                    cmd.cap_rd = 1'b1;
                    state_next = (op_reg == OP_LOOKUP) ? S_EMIT : S_RM_RD;
                end
                else if (at_last)
                begin
                    status_next = ST_NOTFOUND;
                    zero_next   = 1'b1;
                    state_next  = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_RD;
                end
            end

            // fetch the last record to fill the hole
            S_RM_RD:
            begin
                cmd.rd_en  = 1'b1;
                rd_addr    = last_slot[IDX_W-1:0];
                state_next = S_RM_WR;
            end

            S_RM_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wsel_rd = 1'b1;
                count_next  = last_slot;
                state_next  = S_EMIT;
            end

            // hand the result to the output register
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (op_reg == OP_LIST && !last_reg)
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        op_reg     <= op_next;
        status_reg <= status_next;
        zero_reg   <= zero_next;
        last_reg   <= last_next;
    end

    assign count = count_reg;

endmodule

`default_nettype wire

/* src/keyed_record_table_core.sv */
// path: a full or empty answer goes from accept through S_EMIT to the output register, an insert
// through S_INS first; lookup/remove pass S_RD and S_CMP per entry searched, then S_EMIT; remove
// adds S_RM_RD and S_RM_WR for the swap; list passes S_RD, S_CMP and S_EMIT per record
// throughput: one item at a time, the next is taken the cycle after the result is loaded
// reset: record count cleared; stored records are undefined and never read
// before written, so there is no clearing pass
`default_nettype none

module keyed_record_table_core #(
    parameter int MAX_ENTRIES = krt_pkg::MAX_ENTRIES_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    krt_cmd_if.sink   cmd,
    krt_res_if.source rsp
);
    import krt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    dp_cmd_t          dp_cmd;
    dp_stat_t         dp_stat;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic [CNT_W-1:0] count;
    logic             in_ready;

    // controller
    krt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .opcode   (cmd.opcode),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .count    (count)
    );

    assign cmd.ready = in_ready;

    // datapath
    krt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .count        (count),
        .stat         (dp_stat),
        .key_chunk_0  (cmd.key_chunk_0),
        .key_chunk_1  (cmd.key_chunk_1),
        .key_chunk_2  (cmd.key_chunk_2),
        .key_chunk_3  (cmd.key_chunk_3),
        .kind_chunk_0 (cmd.kind_chunk_0),
        .kind_chunk_1 (cmd.kind_chunk_1),
        .kind_chunk_2 (cmd.kind_chunk_2),
        .amount_in    (cmd.amount_in),
        .res_ready    (rsp.ready),
        .res_valid    (rsp.valid),
        .status       (rsp.status),
        .found_key_0  (rsp.found_key_0),
        .found_key_1  (rsp.found_key_1),
        .found_key_2  (rsp.found_key_2),
        .found_key_3  (rsp.found_key_3),
        .found_kind_0 (rsp.found_kind_0),
        .found_kind_1 (rsp.found_kind_1),
        .found_kind_2 (rsp.found_kind_2),
        .amount_out   (rsp.amount_out),
        .fill_count   (rsp.fill_count),
        .last_of_run  (rsp.last_of_run)
    );

endmodule

`default_nettype wire
